### design/easter_holy_day_dates_assert.svh
// ----------------------------------------------------------------------------
// Easter holy day dates - assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during rst.
// ----------------------------------------------------------------------------
`ifndef EASTER_HOLY_DAY_DATES_ASSERT_SVH
`define EASTER_HOLY_DAY_DATES_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EHD_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EHD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

### design/ehd_pkg.sv
// ----------------------------------------------------------------------------
// ehd_pkg
// Widths, computus constants and pipeline control type for the Easter block.
// ----------------------------------------------------------------------------
`default_nettype none

package ehd_pkg;

  localparam int YEAR_W = 14;
  localparam int NSTG   = 9;   // register stages, input to output

  // Computus constants
  localparam int GOLDEN     = 19;
  localparam int CENT       = 100;
  localparam int EPACT_OFS  = 15;
  localparam int WDAY_OFS   = 32 + 70;
  localparam int CORR_LIM   = 451;
  localparam int EOFF_OFS   = 114 - 92;  // base to days after end of February
  localparam int PENTECOST  = 49;

  // Reciprocals for divide by constant (RECIP_25 and RECIP_3 rounded up, rest down)
  localparam logic [13:0] RECIP_100 = 14'd10485;  // 2^20 / 100
  localparam logic [15:0] RECIP_19  = 16'd55188;  // 2^20 / 19
  localparam logic [5:0]  RECIP_25  = 6'd41;      // 2^10 / 25, exact below 172
  localparam logic [7:0]  RECIP_3   = 8'd171;     // 2^9 / 3, exact below 512
  localparam logic [5:0]  RECIP_30  = 6'd34;      // 2^10 / 30
  localparam logic [7:0]  RECIP_7   = 8'd146;     // 2^10 / 7

  typedef struct packed {
    logic [NSTG-1:0] ld;   // stage register load enable
    logic [NSTG-1:0] vld;  // stage holds an item
  } ehd_pipe_t;

endpackage

`default_nettype wire

### design/easter_holy_day_dates.sv
// ----------------------------------------------------------------------------
// easter_holy_day_dates
// Gregorian Easter (anonymous computus) plus Carnival Sunday, Good Friday,
// Ascension Day and Whitsunday, each as month and day of month.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+-------------------
//  in      | in_valid, in_stall, year         | into      | in_valid & !in_stall
//  out     | out_valid, out_stall, *_mon/*_dom| out of    | out_valid & !out_stall
//
//  An input transfer reaches out_valid through the register stages; one year
//  enters per cycle while in_stall is low, and one date set leaves per cycle
//  while out_stall is low. The depth is set by the chain of divide-by-constant
//  steps (year / 100, then the epact, weekday and correction terms).
//  rst (synchronous) clears all stage valid bits; payload is not reset.
//  A stall on out only backs up stages that are occupied: in_stall rises
//  only once every stage holds an item.
//
// ----------------------------------------------------------------------------
`default_nettype none

module easter_holy_day_dates (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ehd_pkg::YEAR_W-1:0] year,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 easter_mon,
  output logic [4:0]                 easter_dom,
  output logic [1:0]                 carnival_mon,
  output logic [4:0]                 carnival_dom,
  output logic [2:0]                 good_friday_mon,
  output logic [4:0]                 good_friday_dom,
  output logic [2:0]                 ascension_mon,
  output logic [4:0]                 ascension_dom,
  output logic [2:0]                 whitsun_mon,
  output logic [4:0]                 whitsun_dom
);
  import ehd_pkg::*;

  ehd_pipe_t pipe;

  ehd_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .pipe      (pipe)
  );

  assign out_valid = pipe.vld[NSTG-1];

  // --------------------------------------------------------------------------
  // Stage 1: reciprocal estimates of year / 100 and year / 19.
  // Both may come out one low; stage 2 fixes that.
  // --------------------------------------------------------------------------
  logic [YEAR_W-1:0] s1_y;
  logic [7:0]        s1_qb;
  logic [9:0]        s1_q19;
  logic [27:0]       prod_b;
  logic [29:0]       prod_19;

  assign prod_b  = 28'(year) * 28'(RECIP_100);
  assign prod_19 = 30'(year) * 30'(RECIP_19);

  always_ff @(posedge clk) begin
    if (pipe.ld[0]) begin
      s1_y   <= year;
      s1_qb  <= prod_b[27:20];
      s1_q19 <= prod_19[29:20];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: century b, year of century c, golden number a.
  // --------------------------------------------------------------------------
  logic [7:0]  s2_b;
  logic [6:0]  s2_c;
  logic [4:0]  s2_a;
  logic [14:0] rb;
  logic [14:0] r19;
  logic [7:0]  b_next;
  logic [6:0]  c_next;
  logic [4:0]  a_next;

  always_comb begin
    rb  = 15'(s1_y) - 15'(s1_qb) * 15'(CENT);
    r19 = 15'(s1_y) - 15'(s1_q19) * 15'(GOLDEN);
    if (rb >= 15'(CENT)) begin
      b_next = s1_qb + 8'd1;
      c_next = 7'(rb - 15'(CENT));
    end else begin
      b_next = s1_qb;
      c_next = 7'(rb);
    end
    if (r19 >= 15'(GOLDEN)) a_next = 5'(r19 - 15'(GOLDEN));
    else                    a_next = 5'(r19);
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[1]) begin
      s2_b <= b_next;
      s2_c <= c_next;
      s2_a <= a_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: b/4, b%4, c/4, c%4, f = (b+8)/25, leap flag.
  // y%4 equals c%4 since 100 is a multiple of 4.
  // --------------------------------------------------------------------------
  logic [4:0] s3_a;
  logic [7:0] s3_b;
  logic [5:0] s3_d;
  logic [1:0] s3_e;
  logic [4:0] s3_i;
  logic [1:0] s3_k;
  logic [2:0] s3_f;
  logic       s3_leap;
  logic [14:0] prod_f;

  assign prod_f = (15'(s2_b) + 15'd8) * 15'(RECIP_25);

  always_ff @(posedge clk) begin
    if (pipe.ld[2]) begin
      s3_a    <= s2_a;
      s3_b    <= s2_b;
      s3_d    <= s2_b[7:2];
      s3_e    <= s2_b[1:0];
      s3_i    <= s2_c[6:2];
      s3_k    <= s2_c[1:0];
      s3_f    <= prod_f[12:10];
      s3_leap <= (s2_c[1:0] == 2'd0) && ((s2_c != 7'd0) || (s2_b[1:0] == 2'd0));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: g = (b - f + 1) / 3.
  // --------------------------------------------------------------------------
  logic [4:0]  s4_a;
  logic [7:0]  s4_b;
  logic [5:0]  s4_d;
  logic [5:0]  s4_g;
  logic [7:0]  s4_wk;   // 102 + 2e + 2i - k
  logic        s4_leap;
  logic [15:0] prod_g;

  assign prod_g = (16'(s3_b) - 16'(s3_f) + 16'd1) * 16'(RECIP_3);

  always_ff @(posedge clk) begin
    if (pipe.ld[3]) begin
      s4_a    <= s3_a;
      s4_b    <= s3_b;
      s4_d    <= s3_d;
      s4_g    <= prod_g[14:9];
      s4_wk   <= 8'(WDAY_OFS) + {5'd0, s3_e, 1'b0} + {2'd0, s3_i, 1'b0} - {6'd0, s3_k};
      s4_leap <= s3_leap;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: epact sum x = 19a + b + 15 - d - g (never negative).
  // --------------------------------------------------------------------------
  logic [4:0] s5_a;
  logic [9:0] s5_x;
  logic [7:0] s5_wk;
  logic       s5_leap;

  always_ff @(posedge clk) begin
    if (pipe.ld[4]) begin
      s5_a    <= s4_a;
      s5_x    <= 10'(s4_a) * 10'(GOLDEN) + 10'(s4_b) + 10'(EPACT_OFS)
                 - 10'(s4_d) - 10'(s4_g);
      s5_wk   <= s4_wk;
      s5_leap <= s4_leap;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: h = x % 30.
  // --------------------------------------------------------------------------
  logic [4:0]  s6_a;
  logic [4:0]  s6_h;
  logic [7:0]  s6_wk;
  logic        s6_leap;
  logic [15:0] prod_h;
  logic [9:0]  rh;
  logic [4:0]  h_next;

  always_comb begin
    prod_h = 16'(s5_x) * 16'(RECIP_30);
    rh     = s5_x - 10'(prod_h[15:10]) * 10'd30;
    if (rh >= 10'd30) h_next = 5'(rh - 10'd30);
    else              h_next = 5'(rh);
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[5]) begin
      s6_a    <= s5_a;
      s6_h    <= h_next;
      s6_wk   <= s5_wk;
      s6_leap <= s5_leap;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: l = (wk - h) % 7.
  // --------------------------------------------------------------------------
  logic [4:0]  s7_a;
  logic [4:0]  s7_h;
  logic [2:0]  s7_l;
  logic        s7_leap;
  logic [7:0]  lv;
  logic [14:0] prod_l;
  logic [7:0]  rl;
  logic [2:0]  l_next;

  always_comb begin
    lv     = s6_wk - 8'(s6_h);
    prod_l = 15'(lv) * 15'(RECIP_7);
    rl     = lv - 8'(prod_l[14:10]) * 8'd7;
    if (rl >= 8'd7) l_next = 3'(rl - 8'd7);
    else            l_next = 3'(rl);
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[6]) begin
      s7_a    <= s6_a;
      s7_h    <= s6_h;
      s7_l    <= l_next;
      s7_leap <= s6_leap;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: correction m (0 or 1) and Easter as days after end of February.
  // March 22 is 22, April 25 is 56.
  // --------------------------------------------------------------------------
  logic [5:0] s8_eoff;
  logic       s8_leap;
  logic [9:0] msum;
  logic [6:0] eoff_next;

  always_comb begin
    msum      = 10'(s7_a) + 10'(s7_h) * 10'd11 + 10'(s7_l) * 10'd22;
    eoff_next = 7'(s7_h) + 7'(s7_l) + 7'(EOFF_OFS);
    if (msum >= 10'(CORR_LIM)) eoff_next = eoff_next - 7'd7;
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[7]) begin
      s8_eoff <= 6'(eoff_next);
      s8_leap <= s7_leap;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: split each offset into month and day. Every date stays within
  // two or three known months, so a compare against fixed bounds picks it.
  // --------------------------------------------------------------------------
  logic [2:0] easter_mon_next, good_friday_mon_next, ascension_mon_next, whitsun_mon_next;
  logic [1:0] carnival_mon_next;
  logic [5:0] easter_dom_next, carnival_dom_next, good_friday_dom_next;
  logic [5:0] ascension_dom_next, whitsun_dom_next;

  always_comb begin
    // Easter
    if (s8_eoff <= 6'd31) begin
      easter_mon_next = 3'd3; easter_dom_next = s8_eoff;
    end else begin
      easter_mon_next = 3'd4; easter_dom_next = s8_eoff - 6'd31;
    end
    // Carnival, 49 days before: February or March
    if (s8_eoff <= 6'(PENTECOST)) begin
      carnival_mon_next = 2'd2; carnival_dom_next = s8_eoff - 6'd21 + 6'(s8_leap);
    end else begin
      carnival_mon_next = 2'd3; carnival_dom_next = s8_eoff - 6'(PENTECOST);
    end
    // Good Friday
    if (s8_eoff <= 6'd33) begin
      good_friday_mon_next = 3'd3; good_friday_dom_next = s8_eoff - 6'd2;
    end else begin
      good_friday_mon_next = 3'd4; good_friday_dom_next = s8_eoff - 6'd33;
    end
    // Ascension, 39 days after
    if (s8_eoff <= 6'd22) begin
      ascension_mon_next = 3'd4; ascension_dom_next = s8_eoff + 6'd8;
    end else if (s8_eoff <= 6'd53) begin
      ascension_mon_next = 3'd5; ascension_dom_next = s8_eoff - 6'd22;
    end else begin
      ascension_mon_next = 3'd6; ascension_dom_next = s8_eoff - 6'd53;
    end
    // Whitsunday, 49 days after
    if (s8_eoff <= 6'd43) begin
      whitsun_mon_next = 3'd5; whitsun_dom_next = s8_eoff - 6'd12;
    end else begin
      whitsun_mon_next = 3'd6; whitsun_dom_next = s8_eoff - 6'd43;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[8]) begin
      easter_mon      <= easter_mon_next;
      easter_dom      <= easter_dom_next[4:0];
      carnival_mon    <= carnival_mon_next;
      carnival_dom    <= carnival_dom_next[4:0];
      good_friday_mon <= good_friday_mon_next;
      good_friday_dom <= good_friday_dom_next[4:0];
      ascension_mon   <= ascension_mon_next;
      ascension_dom   <= ascension_dom_next[4:0];
      whitsun_mon     <= whitsun_mon_next;
      whitsun_dom     <= whitsun_dom_next[4:0];
    end
  end

endmodule

`default_nettype wire

### design/ehd_pipe_ctl.sv
// ----------------------------------------------------------------------------
// ehd_pipe_ctl
// Valid/ready chain for the datapath stages; a bubble anywhere absorbs a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ehd_pipe_ctl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_stall,
  output ehd_pkg::ehd_pipe_t pipe
);
  import ehd_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) vld[s] <= vld[s-1];
      end
    end
  end

  always_comb begin
    pipe.vld   = vld;
    pipe.ld[0] = in_valid && rdy[0];
    for (int s = 1; s < NSTG; s++) begin
      pipe.ld[s] = vld[s-1] && rdy[s];
    end
  end

  assign in_stall = !rdy[0];

endmodule

`default_nettype wire

### design/ehd_checker.sv
// ----------------------------------------------------------------------------
// ehd_checker
// Port-level checks for easter_holy_day_dates, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "easter_holy_day_dates_assert.svh"

module ehd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [ehd_pkg::YEAR_W-1:0] year,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [2:0]                 easter_mon,
  input wire logic [4:0]                 easter_dom,
  input wire logic [1:0]                 carnival_mon,
  input wire logic [4:0]                 carnival_dom,
  input wire logic [2:0]                 good_friday_mon,
  input wire logic [4:0]                 good_friday_dom,
  input wire logic [2:0]                 ascension_mon,
  input wire logic [4:0]                 ascension_dom,
  input wire logic [2:0]                 whitsun_mon,
  input wire logic [4:0]                 whitsun_dom
);
  import ehd_pkg::*;

  logic [YEAR_W-1:0] year_seen;
  assign year_seen = year;

  // Input backs up only when the output side is holding a full pipe.
  `EHD_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall && (year_seen == year), "in_stall without output stall")

  // Ascension is ten days before Whitsunday.
  `EHD_ASSERT_NOW(a_asc_whit, out_valid && (whitsun_dom > 5'd10), (ascension_mon == whitsun_mon) && (ascension_dom == whitsun_dom - 5'd10), "Ascension not ten days before Whitsunday")

  // A held result stays offered.
  `EHD_ASSERT_NEXT(a_valid_hold, out_valid && out_stall, out_valid, "out_valid dropped during stall")

  // A held result does not change.
  `EHD_ASSERT_NEXT(a_data_hold, out_valid && out_stall, $stable({easter_mon, easter_dom, carnival_mon, carnival_dom, good_friday_mon, good_friday_dom, ascension_mon, ascension_dom, whitsun_mon, whitsun_dom}), "result changed during stall")

endmodule

bind easter_holy_day_dates ehd_checker u_ehd_checker (.*);

`default_nettype wire
